/* rtl/dotq_pkg.sv */
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types and constants of the deadline-ordered task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dotq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned ID_W    = 8;
  localparam int unsigned DL_W    = 32;
  localparam int unsigned ENTRY_W = ID_W + DL_W;
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_SORTED  = 2'd0,
    REQ_TAIL    = 2'd1,
    REQ_EXTRACT = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0] tid;
    logic [DL_W-1:0] dl;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/dotq_ram.sv */
// ----------------------------------------------------------------------------
// dotq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dotq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/dotq_cmp.sv */
// ----------------------------------------------------------------------------
// dotq_cmp
// Shared compare unit: deadline order test for sorted insert, id match for
// extract. Used once per visited slot.
// ----------------------------------------------------------------------------
`default_nettype none

module dotq_cmp (
  input  wire logic            by_deadline_i,
  input  wire dotq_pkg::entry_t key_i,
  input  wire dotq_pkg::entry_t slot_i,
  output logic                 hit_o
);
  import dotq_pkg::*;

  always_comb begin
    if (by_deadline_i) begin
      hit_o = (key_i.dl <= slot_i.dl);
    end else begin
      hit_o = (key_i.tid == slot_i.tid);
    end
  end

endmodule

`default_nettype wire

/* rtl/deadline_ordered_task_queue.sv */
// ----------------------------------------------------------------------------
// deadline_ordered_task_queue
// Earliest-deadline-first task list held in a RAM, walked one slot at a
// time by a small sequencer around one shared compare unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | req_type_i, task_id_i, deadline_i
//  out     | output    | out_valid_o / out_stall_i | status_o, head_valid_o, head_task_o,
//          |           |                        | head_deadline_o, entry_total_o
//
// One request at a time: each visited slot is read (S_SCAN), then compared
// (S_TEST); each moved entry is read, then written back; the shift or pull
// then ends, an insert is placed (S_PLACE), and the result is reported.
// Visited and moved slots never exceed DEPTH together.
// Reset empties the list; slot contents stay undefined until written.
// A stalled result holds in the output register; the next result waits in
// the reporting state, so new requests stall.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_ordered_task_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dotq_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [dotq_pkg::ID_W-1:0]     task_id_i,
  input  wire logic [dotq_pkg::DL_W-1:0]     deadline_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [dotq_pkg::STAT_W-1:0]        status_o,
  output logic                               head_valid_o,
  output logic [dotq_pkg::ID_W-1:0]          head_task_o,
  output logic [dotq_pkg::DL_W-1:0]          head_deadline_o,
  output logic [dotq_pkg::TOTAL_W-1:0]       entry_total_o
);
  import dotq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN    = 9'b000000010,
    S_TEST    = 9'b000000100,
    S_MOVE    = 9'b000001000,
    S_MOVE_WR = 9'b000010000,
    S_PLACE   = 9'b000100000,
    S_PULL    = 9'b001000000,
    S_PULL_WR = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     count_q, count_d;
  logic [REQ_W-1:0]  req_q, req_d;
  status_e           status_q, status_d;
  entry_t            key_q, key_d;
  entry_t            head_q;

  logic [CW-1:0]     idx_inc, idx_dec;
  logic              hit;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;

  logic              load_out;
  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_head_valid_q;
  entry_t            out_head_q;
  logic [CW-1:0]     out_total_q;

  assign idx_inc = idx_q + CW'(1);
  assign idx_dec = idx_q - CW'(1);

  dotq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dotq_cmp u_cmp (
    .by_deadline_i (req_q != REQ_EXTRACT),
    .key_i         (key_q),
    .slot_i        (ram_rdata),
    .hit_o         (hit)
  );

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    count_d   = count_q;
    req_d     = req_q;
    status_d  = status_q;
    key_d     = key_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    load_out  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = req_type_i;
          key_d    = '{tid: task_id_i, dl: deadline_i};
          status_d = ST_OK;
          idx_d    = '0;
          unique case (req_type_i) inside
            REQ_SORTED, REQ_TAIL: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else if (req_type_i == REQ_TAIL || count_q == '0) begin
                pos_d   = count_q;
                idx_d   = count_q;
                state_d = S_MOVE;
              end else begin
                state_d = S_SCAN;
              end
            end
            REQ_EXTRACT: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        ram_raddr = idx_q[AW-1:0];
        state_d   = S_TEST;
      end
      S_TEST: begin
        if (hit) begin
          pos_d = idx_q;
          if (req_q == REQ_EXTRACT) begin
            state_d = S_PULL;
          end else begin
            idx_d   = count_q;
            state_d = S_MOVE;
          end
        end else if (idx_inc == count_q) begin
          if (req_q == REQ_EXTRACT) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_DONE;
          end else begin
            pos_d   = count_q;
            idx_d   = count_q;
            state_d = S_MOVE;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_SCAN;
        end
      end
      // open a gap: shift entries toward the tail, last one first
      S_MOVE: begin
        if (idx_q > pos_q) begin
          ram_raddr = idx_dec[AW-1:0];
          state_d   = S_MOVE_WR;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        idx_d     = idx_dec;
        state_d   = S_MOVE;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = key_q;
        count_d   = count_q + CW'(1);
        state_d   = S_DONE;
      end
      // close the gap: pull later entries toward the head
      S_PULL: begin
        if (idx_inc < count_q) begin
          ram_raddr = idx_inc[AW-1:0];
          state_d   = S_PULL_WR;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_PULL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        idx_d     = idx_inc;
        state_d   = S_PULL;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      req_q       <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
      req_q    <= req_d;
      status_q <= status_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    // track slot 0 so the head is known without a read
    if (ram_we && ram_waddr == '0) begin
      head_q <= ram_wdata;
    end
    if (load_out) begin
      out_status_q     <= status_q;
      out_head_valid_q <= (count_q != '0);
      out_head_q       <= (count_q != '0) ? head_q : '0;
      out_total_q      <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign head_valid_o    = out_head_valid_q;
  assign head_task_o     = out_head_q.tid;
  assign head_deadline_o = out_head_q.dl;
  assign entry_total_o   = TOTAL_W'(out_total_q);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_total_o == TOTAL_W'(DEPTH))
    else $error("full status with room left");

  a_move_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOVE_WR |-> idx_q <= count_q && idx_q > pos_q)
    else $error("shift write outside the list");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without starting work");
`endif

endmodule

`default_nettype wire

/* tb/sv/dotq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dotq_checker
// Watches both channels of the deadline-ordered task queue. It keeps its own
// copy of the ordered task list, works out the report for every accepted
// request, and compares each accepted result against the oldest one waiting.
// ----------------------------------------------------------------------------

module dotq_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [dotq_pkg::REQ_W-1:0]     req_type_i,
  input  logic [dotq_pkg::ID_W-1:0]      task_id_i,
  input  logic [dotq_pkg::DL_W-1:0]      deadline_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [dotq_pkg::STAT_W-1:0]    status_i,
  input  logic                           head_valid_i,
  input  logic [dotq_pkg::ID_W-1:0]      head_task_i,
  input  logic [dotq_pkg::DL_W-1:0]      head_deadline_i,
  input  logic [dotq_pkg::TOTAL_W-1:0]   entry_total_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    pending_o,
  output int unsigned                    results_o,
  output int unsigned                    full_seen_o,
  output int unsigned                    missing_seen_o
);
  import dotq_pkg::*;

  typedef struct packed {
    status_e             status;
    logic                head_valid;
    entry_t              head;
    logic [TOTAL_W-1:0]  total;
  } queue_report_t;

  entry_t        ready_slots [DEPTH];
  int unsigned   ready_count = 0;
  queue_report_t pending_reports [$];

  int unsigned mismatch_total = 0;
  int unsigned result_total   = 0;
  int unsigned full_total     = 0;
  int unsigned missing_total  = 0;

  assign mismatches_o   = mismatch_total;
  assign pending_o      = pending_reports.size();
  assign results_o      = result_total;
  assign full_seen_o    = full_total;
  assign missing_seen_o = missing_total;

  // Apply one request to the list and return the report it should produce.
  function automatic queue_report_t apply_request(logic [REQ_W-1:0] req,
                                                  logic [ID_W-1:0]  tid,
                                                  logic [DL_W-1:0]  dl);
    queue_report_t rep;
    int            pos;
    bit            found;
    rep.status = ST_OK;
    pos        = ready_count;
    found      = 1'b0;
    if (req == REQ_SORTED || req == REQ_TAIL) begin
      if (ready_count >= DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        // Sorted insert goes ahead of the first equal or later deadline.
        if (req == REQ_SORTED) begin
          for (int k = ready_count - 1; k >= 0; k--) begin
            if (dl <= ready_slots[k].dl) pos = k;
          end
        end
        for (int k = ready_count; k > pos; k--) ready_slots[k] = ready_slots[k-1];
        ready_slots[pos].tid = tid;
        ready_slots[pos].dl  = dl;
        ready_count++;
      end
    end else if (req == REQ_EXTRACT) begin
      for (int k = 0; k < ready_count; k++) begin
        if (!found && ready_slots[k].tid == tid) begin
          found = 1'b1;
          pos   = k;
        end
      end
      if (found) begin
        for (int k = pos; k + 1 < ready_count; k++) ready_slots[k] = ready_slots[k+1];
        ready_count--;
      end else begin
        rep.status = ST_NOT_FOUND;
      end
    end
    rep.head_valid = (ready_count > 0);
    rep.head       = (ready_count > 0) ? ready_slots[0] : '0;
    rep.total      = ready_count[TOTAL_W-1:0];
    return rep;
  endfunction

  task automatic check_field(string name, logic [DL_W-1:0] want, logic [DL_W-1:0] got);
    if (got !== want) begin
      mismatch_total++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_report_t want;
    if (!rst_ni) begin
      ready_count = 0;
      pending_reports.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        result_total++;
        if (pending_reports.size() == 0) begin
          mismatch_total++;
          $error("result beat with no request outstanding");
        end else begin
          want = pending_reports.pop_front();
          if (want.status == ST_FULL) full_total++;
          if (want.status == ST_NOT_FOUND) missing_total++;
          check_field("status", DL_W'(want.status), DL_W'(status_i));
          check_field("head_valid", DL_W'(want.head_valid), DL_W'(head_valid_i));
          check_field("head_task", DL_W'(want.head.tid), DL_W'(head_task_i));
          check_field("head_deadline", want.head.dl, head_deadline_i);
          check_field("entry_total", DL_W'(want.total), DL_W'(entry_total_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_reports.push_back(apply_request(req_type_i, task_id_i, deadline_i));
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sorted inserts, tail inserts, extracts and the unused request code
// into the deadline-ordered task queue, with random gaps on the request side
// and random stalls on the result side, and gives the verdict of the checker.
// ----------------------------------------------------------------------------

module tb_top;
  import dotq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;
  localparam int               RANDOM_ITEMS = 1525;
  localparam int               QUIET_TAIL   = 150;
  localparam int               LONG_HOLD    = 400;
  localparam int               QUIET_LIMIT  = 4000;
  localparam int               DRAIN_CYCLES = 4 * DEPTH + 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   req_type = '0;
  logic [ID_W-1:0]    task_id = '0;
  logic [DL_W-1:0]    deadline = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic               head_valid;
  logic [ID_W-1:0]    head_task;
  logic [DL_W-1:0]    head_deadline;
  logic [TOTAL_W-1:0] entry_total;

  int unsigned mismatches, pending, results, full_seen, missing_seen;

  int          tx_gap_pct = 0;
  int          rx_gap_pct = 20;
  bit          hold_request = 1'b0;
  int          quiet_cycles = 0;
  int          kind_count [4] = '{default: 0};
  logic [ID_W-1:0] live_tids [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  deadline_ordered_task_queue DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .task_id_i       (task_id),
    .deadline_i      (deadline),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .head_valid_o    (head_valid),
    .head_task_o     (head_task),
    .head_deadline_o (head_deadline),
    .entry_total_o   (entry_total)
  );

  dotq_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .req_type_i      (req_type),
    .task_id_i       (task_id),
    .deadline_i      (deadline),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .head_valid_i    (head_valid),
    .head_task_i     (head_task),
    .head_deadline_i (head_deadline),
    .entry_total_i   (entry_total),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .results_o       (results),
    .full_seen_o     (full_seen),
    .missing_seen_o  (missing_seen)
  );

  // Result side: random stall bursts, plus a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request beat, hold it until accepted, and track live task ids.
  task automatic drive_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] tid,
                           logic [DL_W-1:0] dl);
    int idx;
    @(negedge clk);
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    task_id  <= tid;
    deadline <= dl;
    do @(posedge clk); while (in_stall);
    kind_count[req]++;
    if (req == REQ_SORTED || req == REQ_TAIL) begin
      if (live_tids.size() < DEPTH) live_tids.push_back(tid);
    end else if (req == REQ_EXTRACT) begin
      idx = -1;
      foreach (live_tids[k]) if (idx < 0 && live_tids[k] == tid) idx = k;
      if (idx >= 0) live_tids.delete(idx);
    end
  endtask

  initial begin
    int              roll;
    int              fill_bias;
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0]  tid;
    logic [DL_W-1:0]  dl;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, field extremes, equal deadlines, duplicates.
    drive_req(REQ_EXTRACT, 8'd0, 32'd0);
    drive_req(REQ_SORTED, 8'd0, 32'd0);
    drive_req(REQ_SORTED, 8'hFF, 32'hFFFF_FFFF);
    drive_req(REQ_TAIL, 8'hA5, 32'h5A5A_5A5A);
    drive_req(REQ_SORTED, 8'd1, 32'd0);
    drive_req(REQ_UNUSED, 8'h3C, 32'hC3C3_C3C3);
    drive_req(REQ_TAIL, 8'd0, 32'd100);
    drive_req(REQ_EXTRACT, 8'd0, 32'hFFFF_FFFF);
    drive_req(REQ_EXTRACT, 8'd77, 32'd0);
    for (int k = 0; k < 12; k++) begin
      drive_req(k[0] ? REQ_TAIL : REQ_SORTED, ID_W'(16 + k), $urandom);
    end
    // List is full now: both insert kinds get rejected.
    drive_req(REQ_SORTED, 8'h80, 32'd1);
    drive_req(REQ_TAIL, 8'h7F, 32'd2);
    drive_req(REQ_EXTRACT, 8'hFF, 32'd0);

    fill_bias = 5;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        fill_bias  = $urandom_range(1, 9);
        tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end
      if (n == 400 || n == 1000) hold_request = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < 4) req = REQ_UNUSED;
      else if (roll < 4 + fill_bias * 9) req = ($urandom_range(0, 9) < 7) ? REQ_SORTED : REQ_TAIL;
      else req = REQ_EXTRACT;

      if (req == REQ_EXTRACT && live_tids.size() > 0 && $urandom_range(0, 4) != 0)
        tid = live_tids[$urandom_range(0, live_tids.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
        tid = ID_W'($urandom_range(0, 15));
      else
        tid = ID_W'($urandom_range(0, 255));

      // Cluster deadlines so that ties and extremes come up often.
      case ($urandom_range(0, 3))
        0:       dl = $urandom_range(0, 7);
        1:       dl = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: dl = $urandom;
      endcase

      drive_req(req, tid, dl);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests: %0d sorted, %0d tail, %0d extract, %0d unused code.",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
             kind_count[REQ_SORTED], kind_count[REQ_TAIL], kind_count[REQ_EXTRACT],
             kind_count[REQ_UNUSED]);
    $display("Checked %0d results: %0d inserts into a full list, %0d extracts of absent tasks.",
             results, full_seen, missing_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dotq_pkg.sv
rtl/dotq_ram.sv
rtl/dotq_cmp.sv
rtl/deadline_ordered_task_queue.sv
tb/sv/dotq_checker.sv
tb/sv/tb_top.sv
